// File: hdl/rkf_pkg.sv
// ----------------------------------------------------------------------------
// rkf_pkg
// Shared types, constants and helpers for the RGB 3x3 kernel filter.
// ----------------------------------------------------------------------------
package rkf_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int COORD_W    = $clog2(MAX_WIDTH);
    localparam int SIZE_W     = 11;
    localparam int CHAN_W     = 8;
    localparam int PIX_W      = 3 * CHAN_W;
    localparam int KIND_W     = 2;
    localparam int CFG_ADDR_W = 3;

    localparam logic [KIND_W-1:0] KIND_EDGE    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SHARPEN = 2'd1;
    localparam logic [KIND_W-1:0] KIND_BOX     = 2'd2;
    localparam logic [KIND_W-1:0] KIND_GAUSS   = 2'd3;

    localparam logic [CFG_ADDR_W-1:0] REG_FILTER_KIND  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_WIDTH  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_HEIGHT = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_SEL_LEFT     = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_SEL_RIGHT    = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_SEL_TOP      = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_SEL_BOTTOM   = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_LEVEL    = 3'd7;

    // x/9 as (x * 3641) >> 15, exact for x below 2300
    localparam logic [11:0] RECIP9       = 12'd3641;
    localparam int          RECIP9_SHIFT = 15;

    typedef logic [PIX_W-1:0] pix_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [CHAN_W-1:0] max_level;
    } filt_ctl_t;

    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W-1:0] lim);
        logic [SIZE_W-1:0] r;
        if (v == '0)
            r = SIZE_W'(1);
        else if (v > lim)
            r = lim;
        else
            r = v;
        return r;
    endfunction

endpackage

// File: hdl/rkf_ram.sv
// ----------------------------------------------------------------------------
// rkf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rkf_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: hdl/rkf_filter.sv
// ----------------------------------------------------------------------------
// rkf_filter
// Applies the selected 3x3 kernel to each colour channel, rounds and clamps.
// ----------------------------------------------------------------------------
module rkf_filter (
    input  rkf_pkg::filt_ctl_t ctl,
    input  rkf_pkg::pix_t      win [9],   // row-major, top-left first
    output rkf_pkg::pix_t      result
);

    for (genvar ch = 0; ch < 3; ch++) begin : g_chan
        localparam int SH = ch * rkf_pkg::CHAN_W;

        logic [7:0]         cen;
        logic [9:0]         cross_sum;
        logic [9:0]         corn_sum;
        logic [10:0]        five_c;
        logic [11:0]        box_sum;
        logic [23:0]        box_prod;
        logic [11:0]        gauss_sum;
        logic signed [13:0] v;

        assign cen       = win[4][SH +: 8];
        assign cross_sum = 10'(win[1][SH +: 8]) + 10'(win[3][SH +: 8])
                         + 10'(win[5][SH +: 8]) + 10'(win[7][SH +: 8]);
        assign corn_sum  = 10'(win[0][SH +: 8]) + 10'(win[2][SH +: 8])
                         + 10'(win[6][SH +: 8]) + 10'(win[8][SH +: 8]);
        assign five_c    = {1'b0, cen, 2'b00} + 11'(cen);
        assign box_sum   = 12'(cen) + 12'(cross_sum) + 12'(corn_sum) + 12'd4;
        assign box_prod  = box_sum * rkf_pkg::RECIP9;
        assign gauss_sum = {2'b00, cen, 2'b00} + {1'b0, cross_sum, 1'b0}
                         + 12'(corn_sum) + 12'd8;

        always_comb begin
            case (ctl.kind)
                rkf_pkg::KIND_EDGE: begin
                    v = $signed({3'b000, cen, 3'b000}) - $signed({4'b0000, cross_sum})
                      - $signed({4'b0000, corn_sum});
                end
                rkf_pkg::KIND_SHARPEN: begin
                    v = $signed({3'b000, five_c}) - $signed({4'b0000, cross_sum});
                end
                rkf_pkg::KIND_BOX: begin
                    v = $signed({5'b00000, box_prod[23:rkf_pkg::RECIP9_SHIFT]});
                end
                default: begin
                    v = $signed({6'b000000, gauss_sum[11:4]});
                end
            endcase
        end

        always_comb begin
            if (v < 0)
                result[SH +: 8] = '0;
            else if (v > $signed({6'b000000, ctl.max_level}))
                result[SH +: 8] = ctl.max_level;
            else
                result[SH +: 8] = v[7:0];
        end
    end

endmodule

// File: hdl/rgb_3x3_kernel_filter_core.sv
// ----------------------------------------------------------------------------
// rgb_3x3_kernel_filter_core
// Streaming 3x3 kernel filter over RGB pixels in raster order.
// ----------------------------------------------------------------------------
// Usage:
//  - s_ channel: one RGB pixel per transaction, raster order. Configuration
//    is written through cfg_wr_en/cfg_addr/cfg_wr_data while idle; a write
//    to the width or height restarts the frame at row 0, column 0.
//  - m_ channel: filtered or passed-through pixels with their coordinates.
//    A pixel comes out once its right and lower neighbours are in, so each
//    input causes 0 to 4 output transactions; tlast marks the final one.
//  - Path: an input's line-store read and the input itself are registered
//    in stage 1; its results then pass one by one to the output register.
//  - Throughput: one pixel per cycle while each input yields at most one
//    result and m_tready stays high; at the end of a row and on the last row
//    the single output register drains the result list one result at a time.
//  - Stall: with m_tready low the output register holds and the pending
//    item holds in stage 1; s_tready drops until it drains.
//  - Reset: counters, window and control clear synchronously; the line stores
//    are not cleared (a well-formed frame writes before it reads).
// ----------------------------------------------------------------------------
module rgb_3x3_kernel_filter_core (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_addr,
    input  logic [10:0] cfg_wr_data,
    // input pixels
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,    // red_in, green_in, blue_in
    // results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,    // 4-bit pad, red_out, green_out, blue_out, out_col, out_row
    output logic        m_tlast     // last_of_run
);

    localparam int CW = rkf_pkg::COORD_W;
    localparam int SW = rkf_pkg::SIZE_W;

    // configuration registers
    logic [1:0]  kind_reg;
    logic [SW-1:0] width_reg, height_reg;
    logic [SW-1:0] sel_l_reg, sel_r_reg, sel_t_reg, sel_b_reg;
    logic [7:0]  max_level_reg;

    // raster position of the next input
    logic [CW-1:0] row_reg, col_reg;

    // stage 1: item whose line-store read is in flight
    logic          s1_valid_reg;
    logic [CW-1:0] s1_row_reg, s1_col_reg;
    rkf_pkg::pix_t s1_cur_reg;
    logic [3:0]    pend_reg;
    logic          fwd_reg;
    rkf_pkg::pix_t fwd_up_reg, fwd_mid_reg;

    // window: column c-1 and column c-2, rows r-2, r-1, r
    rkf_pkg::pix_t wc0_reg [3];
    rkf_pkg::pix_t wc1_reg [3];

    // output register
    logic          m_valid_reg, m_last_reg;
    logic [CW-1:0] m_row_reg, m_col_reg;
    rkf_pkg::pix_t m_pix_reg;

    logic [SW-1:0] w_eff, h_eff, wm1, hm1;
    logic [CW-1:0] r_acc, c_acc;
    logic          accept, s1_done, out_free, emit;
    logic [3:0]    mask_acc, sel_bit, pend_rest;
    rkf_pkg::pix_t up_rd, mid_rd, up_v, mid_v, filt_pix;
    rkf_pkg::pix_t win [9];
    rkf_pkg::filt_ctl_t ctl;
    logic [CW-1:0] i_pos, j_pos;
    logic          filt_en;
    logic [CW-1:0] cand_row, cand_col;
    rkf_pkg::pix_t cand_pix;
    logic [SW-1:0] c_inc, r_inc;
    logic          size_wr;

    assign w_eff = rkf_pkg::eff_size(width_reg, SW'(rkf_pkg::MAX_WIDTH));
    assign h_eff = rkf_pkg::eff_size(height_reg, SW'(rkf_pkg::MAX_HEIGHT));
    assign wm1   = w_eff - SW'(1);
    assign hm1   = h_eff - SW'(1);
    assign c_acc = ({1'b0, col_reg} >= w_eff) ? wm1[CW-1:0] : col_reg;
    assign r_acc = ({1'b0, row_reg} >= h_eff) ? hm1[CW-1:0] : row_reg;
    assign c_inc = {1'b0, c_acc} + SW'(1);
    assign r_inc = {1'b0, r_acc} + SW'(1);

    // which results this pixel causes, in emission order
    always_comb begin
        mask_acc[0] = (r_acc != '0) && (c_acc != '0);
        mask_acc[1] = (r_acc != '0) && ({1'b0, c_acc} == wm1);
        mask_acc[2] = ({1'b0, r_acc} == hm1) && (c_acc != '0);
        mask_acc[3] = ({1'b0, r_acc} == hm1) && ({1'b0, c_acc} == wm1);
    end

    assign out_free = !m_valid_reg || m_tready;

    always_comb begin
        if (pend_reg[0])
            sel_bit = 4'b0001;
        else if (pend_reg[1])
            sel_bit = 4'b0010;
        else if (pend_reg[2])
            sel_bit = 4'b0100;
        else
            sel_bit = 4'b1000;
    end

    assign pend_rest = pend_reg & ~sel_bit;
    assign emit      = s1_valid_reg && out_free && (pend_reg != '0);
    assign s1_done   = s1_valid_reg && ((pend_reg == '0) || (out_free && (pend_rest == '0)));
    // no transaction is taken while reset is held
    assign s_tready  = aresetn && (!s1_valid_reg || s1_done);
    assign accept    = s_tvalid && s_tready;
    assign size_wr   = cfg_wr_en &&
                       (cfg_addr == rkf_pkg::REG_IMAGE_WIDTH ||
                        cfg_addr == rkf_pkg::REG_IMAGE_HEIGHT);

    // line stores: read at accept, written back when stage 1 retires
    rkf_ram #(.WIDTH(rkf_pkg::PIX_W), .DEPTH(rkf_pkg::MAX_WIDTH)) u_upper (
        .aclk    (aclk),
        .wr_en   (s1_done),
        .wr_addr (s1_col_reg),
        .wr_data (mid_v),
        .rd_en   (accept),
        .rd_addr (c_acc),
        .rd_data (up_rd)
    );

    rkf_ram #(.WIDTH(rkf_pkg::PIX_W), .DEPTH(rkf_pkg::MAX_WIDTH)) u_middle (
        .aclk    (aclk),
        .wr_en   (s1_done),
        .wr_addr (s1_col_reg),
        .wr_data (s1_cur_reg),
        .rd_en   (accept),
        .rd_addr (c_acc),
        .rd_data (mid_rd)
    );

    // same-column write and read in the same cycle (single-column image): forward
    assign up_v  = fwd_reg ? fwd_up_reg  : up_rd;
    assign mid_v = fwd_reg ? fwd_mid_reg : mid_rd;

    always_comb begin
        for (int t = 0; t < 3; t++) begin
            win[t*3]     = wc1_reg[t];
            win[t*3 + 1] = wc0_reg[t];
        end
        win[2] = up_v;
        win[5] = mid_v;
        win[8] = s1_cur_reg;
    end

    assign ctl.kind      = kind_reg;
    assign ctl.max_level = max_level_reg;

    rkf_filter u_filter (
        .ctl    (ctl),
        .win    (win),
        .result (filt_pix)
    );

    assign i_pos = s1_row_reg - CW'(1);
    assign j_pos = s1_col_reg - CW'(1);
    assign filt_en = ({1'b0, j_pos} >= sel_l_reg) && ({1'b0, j_pos} < sel_r_reg) &&
                     ({1'b0, i_pos} >= sel_t_reg) && ({1'b0, i_pos} < sel_b_reg) &&
                     (i_pos != '0) && ({1'b0, i_pos} != hm1) &&
                     (j_pos != '0) && ({1'b0, j_pos} != wm1);

    always_comb begin
        case (sel_bit)
            4'b0001: begin
                cand_row = i_pos;
                cand_col = j_pos;
                cand_pix = filt_en ? filt_pix : wc0_reg[1];
            end
            4'b0010: begin
                cand_row = i_pos;
                cand_col = s1_col_reg;
                cand_pix = mid_v;
            end
            4'b0100: begin
                cand_row = s1_row_reg;
                cand_col = j_pos;
                cand_pix = wc0_reg[2];
            end
            default: begin
                cand_row = s1_row_reg;
                cand_col = s1_col_reg;
                cand_pix = s1_cur_reg;
            end
        endcase
    end

    // configuration and raster counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kind_reg      <= rkf_pkg::KIND_EDGE;
            width_reg     <= SW'(rkf_pkg::MAX_WIDTH);
            height_reg    <= SW'(rkf_pkg::MAX_HEIGHT);
            sel_l_reg     <= '0;
            sel_r_reg     <= SW'(1024);
            sel_t_reg     <= '0;
            sel_b_reg     <= SW'(1024);
            max_level_reg <= 8'd255;
            row_reg       <= '0;
            col_reg       <= '0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    rkf_pkg::REG_FILTER_KIND:  kind_reg      <= cfg_wr_data[1:0];
                    rkf_pkg::REG_IMAGE_WIDTH:  width_reg     <= cfg_wr_data;
                    rkf_pkg::REG_IMAGE_HEIGHT: height_reg    <= cfg_wr_data;
                    rkf_pkg::REG_SEL_LEFT:     sel_l_reg     <= cfg_wr_data;
                    rkf_pkg::REG_SEL_RIGHT:    sel_r_reg     <= cfg_wr_data;
                    rkf_pkg::REG_SEL_TOP:      sel_t_reg     <= cfg_wr_data;
                    rkf_pkg::REG_SEL_BOTTOM:   sel_b_reg     <= cfg_wr_data;
                    default:                   max_level_reg <= cfg_wr_data[7:0];
                endcase
            end
            if (size_wr) begin
                row_reg <= '0;
                col_reg <= '0;
            end else if (accept) begin
                if (c_inc >= w_eff) begin
                    col_reg <= '0;
                    row_reg <= (r_inc >= h_eff) ? '0 : r_inc[CW-1:0];
                end else begin
                    col_reg <= c_inc[CW-1:0];
                    row_reg <= r_acc;
                end
            end
        end
    end

    // stage 1 control and window
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            pend_reg     <= '0;
            fwd_reg      <= 1'b0;
            for (int t = 0; t < 3; t++) begin
                wc0_reg[t] <= '0;
                wc1_reg[t] <= '0;
            end
        end else begin
            if (accept) begin
                s1_valid_reg <= 1'b1;
                pend_reg     <= mask_acc;
                fwd_reg      <= s1_done && (s1_col_reg == c_acc);
            end else begin
                if (s1_done)
                    s1_valid_reg <= 1'b0;
                if (emit)
                    pend_reg <= pend_rest;
            end
            if (s1_done) begin
                for (int t = 0; t < 3; t++)
                    wc1_reg[t] <= wc0_reg[t];
                wc0_reg[0] <= up_v;
                wc0_reg[1] <= mid_v;
                wc0_reg[2] <= s1_cur_reg;
            end
        end
    end

    // stage 1 payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_row_reg  <= r_acc;
            s1_col_reg  <= c_acc;
            s1_cur_reg  <= s_tdata;
            fwd_up_reg  <= mid_v;
            fwd_mid_reg <= s1_cur_reg;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_row_reg  <= cand_row;
            m_col_reg  <= cand_col;
            m_pix_reg  <= cand_pix;
            m_last_reg <= (pend_rest == '0);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {4'b0000, m_pix_reg, m_col_reg, m_row_reg};

endmodule
